// ===== sv/led_cfp_pkg.sv =====
// Package for the LED command frame parser: parse positions, field kinds,
// status codes, state and result types, payload and code lookup functions.
// No dependencies.
`default_nettype none

package led_cfp_pkg;

    localparam int unsigned POS_W     = 5;
    localparam int unsigned BIF_W     = 2;
    localparam int unsigned PART_W    = 24;
    localparam int unsigned KIND_W    = 4;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_CODES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_CODES    = 2'd3;

    // Parse positions
    localparam logic [POS_W-1:0] POS_HEAD1     = 5'd0;
    localparam logic [POS_W-1:0] POS_HEAD2     = 5'd1;
    localparam logic [POS_W-1:0] POS_SIZE      = 5'd2;
    localparam logic [POS_W-1:0] POS_CMD       = 5'd3;
    localparam logic [POS_W-1:0] POS_POWER     = 5'd4;
    localparam logic [POS_W-1:0] POS_MODE      = 5'd5;
    localparam logic [POS_W-1:0] POS_ADDR      = 5'd6;
    localparam logic [POS_W-1:0] POS_PAY_FIRST = 5'd7;
    localparam logic [POS_W-1:0] POS_PAY_LAST  = 5'd20;
    localparam logic [POS_W-1:0] POS_TAIL1     = 5'd21;
    localparam logic [POS_W-1:0] POS_TAIL2     = 5'd22;

    // Field kinds
    localparam logic [KIND_W-1:0] KIND_SIZE     = 4'd0;
    localparam logic [KIND_W-1:0] KIND_CMD      = 4'd1;
    localparam logic [KIND_W-1:0] KIND_POWER    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_MODE     = 4'd3;
    localparam logic [KIND_W-1:0] KIND_COLOR    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_DURATION = 4'd5;
    localparam logic [KIND_W-1:0] KIND_INTERVAL = 4'd6;
    localparam logic [KIND_W-1:0] KIND_EASE     = 4'd7;
    localparam logic [KIND_W-1:0] KIND_LEN      = 4'd8;
    localparam logic [KIND_W-1:0] KIND_GAP      = 4'd9;
    localparam logic [KIND_W-1:0] KIND_FADE     = 4'd10;
    localparam logic [KIND_W-1:0] KIND_HEAD     = 4'd11;
    localparam logic [KIND_W-1:0] KIND_TAIL     = 4'd12;
    localparam logic [KIND_W-1:0] KIND_DIR      = 4'd13;
    localparam logic [KIND_W-1:0] KIND_SPEED    = 4'd14;
    localparam logic [KIND_W-1:0] KIND_ADDRESS  = 4'd15;

    // Frame status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_HEAD = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CMD  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_MODE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_TAIL = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd5;

    // Code slots inside a 32-bit code register, most significant first
    localparam logic [1:0] SLOT_WRITE = 2'd0;
    localparam logic [1:0] SLOT_MATCH = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [BIF_W-1:0]  bif;
        logic [PART_W-1:0] partial;
        logic              closed;
    } parse_state_t;

    typedef struct packed {
        logic [KIND_W-1:0]   field_kind;
        logic [VALUE_W-1:0]  field_value;
        logic                is_status;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              two_byte;
        logic [POS_W-1:0]  next;
    } pay_entry_t;

    typedef struct packed {
        logic       found;
        logic [1:0] idx;
    } code_hit_t;

    // Payload steps: one entry per position from POS_PAY_FIRST to POS_PAY_LAST
    function automatic pay_entry_t pay_lookup(input logic [POS_W-1:0] pos);
        pay_entry_t e;
        case (pos)
            5'd7:    e = '{KIND_COLOR,    1'b1, POS_TAIL1};
            5'd8:    e = '{KIND_COLOR,    1'b1, 5'd9};
            5'd9:    e = '{KIND_DURATION, 1'b1, 5'd10};
            5'd10:   e = '{KIND_INTERVAL, 1'b1, 5'd11};
            5'd11:   e = '{KIND_EASE,     1'b0, POS_TAIL1};
            5'd12:   e = '{KIND_COLOR,    1'b1, 5'd13};
            5'd13:   e = '{KIND_LEN,      1'b0, 5'd14};
            5'd14:   e = '{KIND_GAP,      1'b0, 5'd15};
            5'd15:   e = '{KIND_FADE,     1'b0, 5'd16};
            5'd16:   e = '{KIND_HEAD,     1'b0, 5'd17};
            5'd17:   e = '{KIND_TAIL,     1'b0, 5'd18};
            5'd18:   e = '{KIND_DIR,      1'b0, 5'd19};
            5'd19:   e = '{KIND_SPEED,    1'b1, POS_TAIL1};
            5'd20:   e = '{KIND_SPEED,    1'b1, POS_TAIL1};
            default: e = '{KIND_SIZE,     1'b0, POS_TAIL1};
        endcase
        return e;
    endfunction

    // First payload position of each mode: normal, breathing, lightbeam, rainbow
    function automatic logic [POS_W-1:0] mode_start(input logic [1:0] k);
        logic [POS_W-1:0] p;
        case (k)
            2'd0:    p = 5'd7;
            2'd1:    p = 5'd8;
            2'd2:    p = 5'd12;
            default: p = 5'd20;
        endcase
        return p;
    endfunction

    // Match a byte against four codes; the most significant slot wins on duplicates
    function automatic code_hit_t find_code(input logic [31:0] codes,
                                            input logic [7:0]  b);
        code_hit_t h;
        h = '{1'b0, 2'd0};
        for (int k = 3; k >= 0; k--) begin
            if (codes[8*(3-k) +: 8] == b) begin
                h.found = 1'b1;
                h.idx   = 2'(k);
            end
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== sv/led_cfp_if.sv =====
// Handshake channels of the LED command frame parser: the byte input channel
// and the field/status result channel. Depends on led_cfp_pkg.
`default_nettype none

interface led_cfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input last_byte, output ready);
endinterface

interface led_cfp_out_if import led_cfp_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   field_kind;
    logic [VALUE_W-1:0]  field_value;
    logic                is_status;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output field_kind, output field_value,
                    output is_status, output status, input ready);
    modport sink   (input valid, input field_kind, input field_value,
                    input is_status, input status, output ready);
endinterface

`default_nettype wire

// ===== sv/led_cfp_step.sv =====
// One parse step: next parse state and optional result for one received byte.
// Depends on led_cfp_pkg.
`default_nettype none

module led_cfp_step
    import led_cfp_pkg::*;
(
    input  parse_state_t cur_state,
    input  logic [7:0]   data_byte,
    input  logic         first_byte,
    input  logic         last_byte,
    input  logic [15:0]  head_bytes,
    input  logic [15:0]  tail_bytes,
    input  logic [31:0]  command_codes,
    input  logic [31:0]  mode_codes,
    output parse_state_t nxt_state,
    output logic         res_valid,
    output result_t      res
);

    parse_state_t st;
    logic         skip;
    code_hit_t    cmd_hit;
    code_hit_t    mode_hit;
    pay_entry_t   pay;
    logic [VALUE_W-1:0] assembled;

    assign cmd_hit   = find_code(command_codes, data_byte);
    assign mode_hit  = find_code(mode_codes, data_byte);
    assign pay       = pay_lookup(cur_state.pos);
    assign assembled = {cur_state.partial, data_byte};

    always_comb
    begin
        st        = cur_state;
        skip      = 1'b0;
        res_valid = 1'b0;
        res       = '0;

        if (first_byte)
        begin
            st.pos     = POS_HEAD1;
            st.bif     = '0;
            st.partial = '0;
            st.closed  = 1'b0;
        end
        else if (cur_state.closed)
        begin
            skip = 1'b1;
        end

        if (!skip)
        begin
            case (st.pos)
                POS_HEAD1:
                begin
                    if (data_byte == head_bytes[15:8])
                        st.pos = POS_HEAD2;
                    else
                    begin
                        res_valid = 1'b1;
                        res       = '{'0, '0, 1'b1, ST_BAD_HEAD};
                        st.closed = 1'b1;
                    end
                end
                POS_HEAD2:
                begin
                    if (data_byte == head_bytes[7:0])
                        st.pos = POS_SIZE;
                    else
                    begin
                        res_valid = 1'b1;
                        res       = '{'0, '0, 1'b1, ST_BAD_HEAD};
                        st.closed = 1'b1;
                    end
                end
                POS_SIZE:
                begin
                    res_valid = 1'b1;
                    res       = '{KIND_SIZE, VALUE_W'(data_byte), 1'b0, ST_OK};
                    st.pos    = POS_CMD;
                end
                POS_CMD:
                begin
                    res_valid = 1'b1;
                    if (!cmd_hit.found)
                    begin
                        res       = '{'0, '0, 1'b1, ST_BAD_CMD};
                        st.closed = 1'b1;
                    end
                    else
                    begin
                        res = '{KIND_CMD, VALUE_W'(data_byte), 1'b0, ST_OK};
                        if (cmd_hit.idx == SLOT_WRITE)
                            st.pos = POS_POWER;
                        else if (cmd_hit.idx == SLOT_MATCH)
                            st.pos = POS_ADDR;
                        else
                            st.pos = POS_TAIL1;
                    end
                end
                POS_POWER:
                begin
                    res_valid = 1'b1;
                    res       = '{KIND_POWER, VALUE_W'(data_byte), 1'b0, ST_OK};
                    st.pos    = POS_MODE;
                end
                POS_MODE:
                begin
                    res_valid = 1'b1;
                    if (!mode_hit.found)
                    begin
                        res       = '{'0, '0, 1'b1, ST_BAD_MODE};
                        st.closed = 1'b1;
                    end
                    else
                    begin
                        res    = '{KIND_MODE, VALUE_W'(data_byte), 1'b0, ST_OK};
                        st.pos = mode_start(mode_hit.idx);
                    end
                end
                POS_ADDR:
                begin
                    if (st.bif == 2'd3)
                    begin
                        res_valid  = 1'b1;
                        res        = '{KIND_ADDRESS, assembled, 1'b0, ST_OK};
                        st.bif     = '0;
                        st.partial = '0;
                        st.pos     = POS_TAIL1;
                    end
                    else
                    begin
                        st.partial = assembled[PART_W-1:0];
                        st.bif     = st.bif + 2'd1;
                    end
                end
                POS_TAIL1:
                begin
                    if (data_byte == tail_bytes[15:8])
                        st.pos = POS_TAIL2;
                    else
                    begin
                        res_valid = 1'b1;
                        res       = '{'0, '0, 1'b1, ST_BAD_TAIL};
                        st.closed = 1'b1;
                    end
                end
                POS_TAIL2:
                begin
                    res_valid = 1'b1;
                    st.closed = 1'b1;
                    if (data_byte == tail_bytes[7:0])
                        res = '{'0, '0, 1'b1, ST_OK};
                    else
                        res = '{'0, '0, 1'b1, ST_BAD_TAIL};
                end
                default:
                begin
                    if (st.pos >= POS_PAY_FIRST && st.pos <= POS_PAY_LAST)
                    begin
                        // a one-byte field completes at once, a two-byte one on its second byte
                        if (!pay.two_byte || st.bif != 2'd0)
                        begin
                            res_valid  = 1'b1;
                            res        = '{pay.kind, assembled, 1'b0, ST_OK};
                            st.bif     = '0;
                            st.partial = '0;
                            st.pos     = pay.next;
                        end
                        else
                        begin
                            st.partial = assembled[PART_W-1:0];
                            st.bif     = st.bif + 2'd1;
                        end
                    end
                    else
                    begin
                        // position out of the frame map: close without a report
                        st.closed = 1'b1;
                    end
                end
            endcase

            if (!st.closed && last_byte)
            begin
                res_valid = 1'b1;
                res       = '{'0, '0, 1'b1, ST_TRUNC};
                st.closed = 1'b1;
            end
        end
    end

    assign nxt_state = st;

endmodule

`default_nettype wire

// ===== sv/led_cfp_out_buf.sv =====
// Two-entry result buffer: a registered output slot and a skid slot behind it.
// Depends on led_cfp_pkg.
`default_nettype none

module led_cfp_out_buf
    import led_cfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    has_room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    slot0_reg;
    result_t    slot0_next;
    result_t    slot1_reg;
    result_t    slot1_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;
    assign has_room  = (count_reg != 2'd2);
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
        case (count_reg)
            2'd0:
            begin
                if (push)
                    slot0_next = push_data;
            end
            2'd1:
            begin
                if (push && pop)
                    slot0_next = push_data;
                else if (push)
                    slot1_next = push_data;
            end
            default:
            begin
                if (pop)
                    slot0_next = slot1_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

// ===== sv/led_command_frame_parser.sv =====
// Top level of the LED command frame parser: configuration registers, parse
// state, one-step parse logic and the result buffer.
// Depends on led_cfp_pkg, led_cfp_if, led_cfp_step, led_cfp_out_buf.
//
//   channel  | direction | payload                                     | handshake
//   ---------+-----------+---------------------------------------------+-------------
//   in_ch    | in        | data_byte, first_byte, last_byte            | valid/ready
//   out_ch   | out       | field_kind, field_value, is_status, status  | valid/ready
//   cfg      | in        | cfg_index (2b), cfg_data (32b)              | cfg_we only
//
// Cycles: a byte is taken whenever the two-entry result buffer has a free slot,
// so with a ready consumer the sustained rate is one byte per clock. The parse
// step is a short piece of logic from the parse state registers to the result
// buffer, which registers each result as its byte is taken.
// Reset clears the parse state to "closed, waiting for a first byte", the
// configuration registers to zero and the result buffer to empty.
// Stalls: when out_ch.ready stays low, the buffer fills and in_ch.ready drops
// after at most two results are held.
`default_nettype none

module led_command_frame_parser
    import led_cfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    led_cfp_in_if.sink           in_ch,
    led_cfp_out_if.source        out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Configuration registers
    logic [15:0] head_bytes_reg;
    logic [15:0] tail_bytes_reg;
    logic [31:0] command_codes_reg;
    logic [31:0] mode_codes_reg;

    // Parse state
    parse_state_t state_reg;
    parse_state_t state_next;

    logic    accept;
    logic    res_valid;
    result_t res;
    logic    has_room;
    result_t out_data;

    // Take a byte whenever the result buffer can hold what it may produce
    assign in_ch.ready = has_room;
    assign accept      = in_ch.valid && has_room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_bytes_reg    <= '0;
            tail_bytes_reg    <= '0;
            command_codes_reg <= '0;
            mode_codes_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HEAD_BYTES:    head_bytes_reg    <= cfg_data[15:0];
                REG_TAIL_BYTES:    tail_bytes_reg    <= cfg_data[15:0];
                REG_COMMAND_CODES: command_codes_reg <= cfg_data;
                REG_MODE_CODES:    mode_codes_reg    <= cfg_data;
                default:           head_bytes_reg    <= head_bytes_reg;
            endcase
        end
    end

    led_cfp_step u_step (
        .cur_state     (state_reg),
        .data_byte     (in_ch.data_byte),
        .first_byte    (in_ch.first_byte),
        .last_byte     (in_ch.last_byte),
        .head_bytes    (head_bytes_reg),
        .tail_bytes    (tail_bytes_reg),
        .command_codes (command_codes_reg),
        .mode_codes    (mode_codes_reg),
        .nxt_state     (state_next),
        .res_valid     (res_valid),
        .res           (res)
    );

    // Advance the parse state only on an accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pos     <= POS_HEAD1;
            state_reg.bif     <= '0;
            state_reg.partial <= '0;
            state_reg.closed  <= 1'b1;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Hold results until the consumer takes them
    led_cfp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .has_room  (has_room),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    assign out_ch.field_kind  = out_data.field_kind;
    assign out_ch.field_value = out_data.field_value;
    assign out_ch.is_status   = out_data.is_status;
    assign out_ch.status      = out_data.status;

endmodule

`default_nettype wire

// ===== tb/led_cfp_checker.sv =====
// Scoreboard for the LED command frame parser: follows register writes, predicts
// the result of every byte the block takes and compares each result it gives.
// Depends on led_cfp_pkg and led_cfp_if.
module led_cfp_checker
    import led_cfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    led_cfp_in_if                in_ch,
    led_cfp_out_if               out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   failures,
    output int                   pending,
    output int                   bytes_taken,
    output int                   fields_seen,
    output int                   statuses_seen,
    output int                   frames_ok
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              wide;   // two bytes, high byte first
        logic              ends;   // last field of the mode payload
    } pay_field_t;

    // Register copies
    logic [15:0]       cfg_head;
    logic [15:0]       cfg_tail;
    logic [31:0]       cfg_cmds;
    logic [31:0]       cfg_modes;

    // Parse state
    logic [POS_W-1:0]  at_pos;
    logic [BIF_W-1:0]  bytes_held;
    logic [PART_W-1:0] held_value;
    logic              closed;

    result_t           awaited_results[$];
    result_t           got_item;
    result_t           want_item;
    result_t           next_item;

    function automatic pay_field_t payload_field(input logic [POS_W-1:0] p);
        pay_field_t f;
        case (p - POS_PAY_FIRST)
            5'd0:    f = '{KIND_COLOR,    1'b1, 1'b1};   // normal
            5'd1:    f = '{KIND_COLOR,    1'b1, 1'b0};   // breathing
            5'd2:    f = '{KIND_DURATION, 1'b1, 1'b0};
            5'd3:    f = '{KIND_INTERVAL, 1'b1, 1'b0};
            5'd4:    f = '{KIND_EASE,     1'b0, 1'b1};
            5'd5:    f = '{KIND_COLOR,    1'b1, 1'b0};   // lightbeam
            5'd6:    f = '{KIND_LEN,      1'b0, 1'b0};
            5'd7:    f = '{KIND_GAP,      1'b0, 1'b0};
            5'd8:    f = '{KIND_FADE,     1'b0, 1'b0};
            5'd9:    f = '{KIND_HEAD,     1'b0, 1'b0};
            5'd10:   f = '{KIND_TAIL,     1'b0, 1'b0};
            5'd11:   f = '{KIND_DIR,      1'b0, 1'b0};
            5'd12:   f = '{KIND_SPEED,    1'b1, 1'b1};
            default: f = '{KIND_SPEED,    1'b1, 1'b1};   // rainbow
        endcase
        return f;
    endfunction

    // Slot of a byte among four codes, leftmost first; -1 when none matches
    function automatic int code_slot(input logic [31:0] codes, input logic [7:0] b);
        for (int k = 0; k < 4; k++)
            if (codes[8*(3-k) +: 8] == b)
                return k;
        return -1;
    endfunction

    function automatic result_t field_item(input logic [KIND_W-1:0] k,
                                           input logic [VALUE_W-1:0] v);
        return '{k, v, 1'b0, '0};
    endfunction

    function automatic result_t frame_end(input logic [STATUS_W-1:0] s);
        closed = 1'b1;
        return '{'0, '0, 1'b1, s};
    endfunction

    // Advance the parse by one byte; return 1 when the byte yields a result
    function automatic bit parse_byte(input logic [7:0] b, input logic first,
                                      input logic last, output result_t r);
        int         slot;
        pay_field_t pf;
        bit         hit;
        hit = 1'b0;
        r   = '0;
        if (first)
        begin
            at_pos     = POS_HEAD1;
            bytes_held = '0;
            held_value = '0;
            closed     = 1'b0;
        end
        else if (closed)
        begin
            return 1'b0;
        end
        case (at_pos)
            POS_HEAD1:
            begin
                if (b == cfg_head[15:8]) at_pos = POS_HEAD2;
                else
                begin
                    r = frame_end(ST_BAD_HEAD);
                    hit = 1'b1;
                end
            end
            POS_HEAD2:
            begin
                if (b == cfg_head[7:0]) at_pos = POS_SIZE;
                else
                begin
                    r = frame_end(ST_BAD_HEAD);
                    hit = 1'b1;
                end
            end
            POS_SIZE:
            begin
                r = field_item(KIND_SIZE, 32'(b));
                hit = 1'b1;
                at_pos = POS_CMD;
            end
            POS_CMD:
            begin
                slot = code_slot(cfg_cmds, b);
                hit = 1'b1;
                if (slot < 0) r = frame_end(ST_BAD_CMD);
                else
                begin
                    r = field_item(KIND_CMD, 32'(b));
                    if (slot == SLOT_WRITE) at_pos = POS_POWER;
                    else if (slot == SLOT_MATCH) at_pos = POS_ADDR;
                    else at_pos = POS_TAIL1;
                end
            end
            POS_POWER:
            begin
                r = field_item(KIND_POWER, 32'(b));
                hit = 1'b1;
                at_pos = POS_MODE;
            end
            POS_MODE:
            begin
                slot = code_slot(cfg_modes, b);
                hit = 1'b1;
                if (slot < 0) r = frame_end(ST_BAD_MODE);
                else
                begin
                    r = field_item(KIND_MODE, 32'(b));
                    case (slot)
                        0:       at_pos = POS_PAY_FIRST;
                        1:       at_pos = POS_PAY_FIRST + 5'd1;
                        2:       at_pos = POS_PAY_FIRST + 5'd5;
                        default: at_pos = POS_PAY_LAST;
                    endcase
                end
            end
            POS_ADDR:
            begin
                if (bytes_held == 2'd3)
                begin
                    r = field_item(KIND_ADDRESS, {held_value, b});
                    hit = 1'b1;
                    bytes_held = '0;
                    held_value = '0;
                    at_pos = POS_TAIL1;
                end
                else
                begin
                    held_value = {held_value[15:0], b};
                    bytes_held = bytes_held + 2'd1;
                end
            end
            POS_TAIL1:
            begin
                if (b == cfg_tail[15:8]) at_pos = POS_TAIL2;
                else
                begin
                    r = frame_end(ST_BAD_TAIL);
                    hit = 1'b1;
                end
            end
            POS_TAIL2:
            begin
                r = frame_end(b == cfg_tail[7:0] ? ST_OK : ST_BAD_TAIL);
                hit = 1'b1;
            end
            default:
            begin
                if (at_pos >= POS_PAY_FIRST && at_pos <= POS_PAY_LAST)
                begin
                    pf = payload_field(at_pos);
                    if (pf.wide && bytes_held == '0)
                    begin
                        held_value = {held_value[15:0], b};
                        bytes_held = bytes_held + 2'd1;
                    end
                    else
                    begin
                        r = field_item(pf.kind, {held_value, b});
                        hit = 1'b1;
                        bytes_held = '0;
                        held_value = '0;
                        at_pos = pf.ends ? POS_TAIL1 : at_pos + 5'd1;
                    end
                end
                else
                begin
                    closed = 1'b1;
                end
            end
        endcase
        // a last byte inside an open frame replaces whatever it completed
        if (!closed && last)
        begin
            r = frame_end(ST_TRUNC);
            hit = 1'b1;
        end
        return hit;
    endfunction

    task automatic flag(input string msg);
        failures++;
        if (failures <= 10)
            $display("%0t ns: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_head   = '0;
            cfg_tail   = '0;
            cfg_cmds   = '0;
            cfg_modes  = '0;
            at_pos     = POS_HEAD1;
            bytes_held = '0;
            held_value = '0;
            closed     = 1'b1;
            awaited_results.delete();
            failures      = 0;
            pending       = 0;
            bytes_taken   = 0;
            fields_seen   = 0;
            statuses_seen = 0;
            frames_ok     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HEAD_BYTES:    cfg_head  = cfg_data[15:0];
                    REG_TAIL_BYTES:    cfg_tail  = cfg_data[15:0];
                    REG_COMMAND_CODES: cfg_cmds  = cfg_data;
                    REG_MODE_CODES:    cfg_modes = cfg_data;
                    default: ;
                endcase
            end
            // results are registered in the buffer after their byte is taken, so check before predicting
            if (out_ch.valid && out_ch.ready)
            begin
                got_item = '{out_ch.field_kind, out_ch.field_value,
                             out_ch.is_status, out_ch.status};
                if (got_item.is_status)
                begin
                    statuses_seen++;
                    if (got_item.status == ST_OK) frames_ok++;
                end
                else
                begin
                    fields_seen++;
                end
                if (awaited_results.size() == 0)
                begin
                    flag($sformatf("unexpected result: kind %0d value %h end %0b status %0d",
                                   got_item.field_kind, got_item.field_value,
                                   got_item.is_status, got_item.status));
                end
                else
                begin
                    want_item = awaited_results.pop_front();
                    if (got_item.field_kind  !== want_item.field_kind  ||
                        got_item.field_value !== want_item.field_value ||
                        got_item.is_status   !== want_item.is_status   ||
                        got_item.status      !== want_item.status)
                        flag($sformatf({"result mismatch: expected kind %0d value %h end %0b",
                                        " status %0d, got kind %0d value %h end %0b status %0d"},
                                       want_item.field_kind, want_item.field_value,
                                       want_item.is_status, want_item.status,
                                       got_item.field_kind, got_item.field_value,
                                       got_item.is_status, got_item.status));
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                bytes_taken++;
                if (parse_byte(in_ch.data_byte, in_ch.first_byte, in_ch.last_byte, next_item))
                    awaited_results.push_back(next_item);
            end
            pending = awaited_results.size();
        end
    end

endmodule

// ===== tb/led_command_frame_parser_test.sv =====
// Testbench top for the LED command frame parser: clock, reset, register
// settings, byte stimulus and result back-pressure; checking sits in led_cfp_checker.
// Depends on led_cfp_pkg, led_cfp_if, led_cfp_checker and the parser itself.
module led_command_frame_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import led_cfp_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    led_cfp_in_if  in_ch ();
    led_cfp_out_if out_ch ();

    int failures;
    int pending;
    int bytes_taken;
    int fields_seen;
    int statuses_seen;
    int frames_ok;

    // Stimulus state: current register settings mirror what was last written
    bit          bursts_on;
    int          stall_left;
    int          frame_items;
    int          settings_loaded;
    logic [15:0] cur_head;
    logic [15:0] cur_tail;
    logic [31:0] cur_cmds;
    logic [31:0] cur_modes;
    logic [7:0]  frame_bytes[$];

    led_command_frame_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    led_cfp_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .failures      (failures),
        .pending       (pending),
        .bytes_taken   (bytes_taken),
        .fields_seen   (fields_seen),
        .statuses_seen (statuses_seen),
        .frames_ok     (frames_ok)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Hard stop: far beyond the slowest legal run
    initial
    begin
        #1_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("CHECK FAILED");
        $finish;
    end

    // Result back-pressure: drop ready in random bursts while bursts are on
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    // Offer one byte at the falling edge and hold it until the block takes it
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        if (bursts_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.first_byte <= first;
        in_ch.last_byte  <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid, wait for every predicted result, then let the pipeline run dry
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all four registers back to back; only called while the block is idle
    task automatic apply_settings(input logic [15:0] h, input logic [15:0] t,
                                  input logic [31:0] c, input logic [31:0] m);
        logic [CFG_IDX_W-1:0] regs[4];
        logic [CFG_W-1:0]     vals[4];
        regs = '{REG_HEAD_BYTES, REG_TAIL_BYTES, REG_COMMAND_CODES, REG_MODE_CODES};
        vals = '{32'(h), 32'(t), c, m};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_we    <= 1'b0;
        cur_head  = h;
        cur_tail  = t;
        cur_cmds  = c;
        cur_modes = m;
        settings_loaded++;
    endtask

    // Four code bytes; with repeats, write shadows read and ack shadows match
    function automatic logic [31:0] random_codes(input bit with_repeats);
        logic [31:0] c;
        bit          clash;
        do
        begin
            c = $urandom;
            clash = 1'b0;
            for (int i = 0; i < 4; i++)
                for (int j = i + 1; j < 4; j++)
                    if (c[8*i +: 8] == c[8*j +: 8]) clash = 1'b1;
        end
        while (clash && !with_repeats);
        if (with_repeats)
        begin
            c[23:16] = c[31:24];
            c[7:0]   = c[15:8];
        end
        return c;
    endfunction

    // Assemble a well-formed frame for the current settings with random content
    task automatic build_frame();
        int slot;
        int mode;
        int body;
        frame_bytes.delete();
        frame_bytes.push_back(cur_head[15:8]);
        frame_bytes.push_back(cur_head[7:0]);
        frame_bytes.push_back(8'($urandom));
        slot = $urandom_range(0, 3);
        frame_bytes.push_back(cur_cmds[8*(3-slot) +: 8]);
        if (slot == SLOT_WRITE)
        begin
            frame_bytes.push_back(8'($urandom));
            mode = $urandom_range(0, 3);
            frame_bytes.push_back(cur_modes[8*(3-mode) +: 8]);
            // normal and rainbow: one 16-bit field; breathing: 7 bytes; lightbeam: 10
            case (mode)
                1:       body = 7;
                2:       body = 10;
                default: body = 2;
            endcase
            repeat (body) frame_bytes.push_back(8'($urandom));
        end
        else if (slot == SLOT_MATCH)
        begin
            repeat (4) frame_bytes.push_back(8'($urandom));
        end
        frame_bytes.push_back(cur_tail[15:8]);
        frame_bytes.push_back(cur_tail[7:0]);
    endtask

    // Send a frame, mostly intact; sometimes corrupt a byte, cut it short with
    // last_byte, abandon it for the next first byte, or trail bytes after close
    task automatic send_frame();
        int   style;
        int   cut;
        int   spot;
        logic mark_last;
        build_frame();
        style = $urandom_range(0, 11);
        cut = frame_bytes.size();
        if (style < 2)
        begin
            spot = $urandom_range(0, cut - 1);
            frame_bytes[spot] = 8'($urandom);
        end
        else if (style < 4)
        begin
            cut = $urandom_range(1, cut - 1);
        end
        for (int i = 0; i < cut; i++)
        begin
            mark_last = (i == cut - 1) && (style == 2 || (style >= 4 && $urandom_range(0, 1)));
            send_byte(frame_bytes[i], i == 0, mark_last);
            frame_items++;
        end
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int quota;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.first_byte = 1'b0;
        in_ch.last_byte  = 1'b0;
        out_ch.ready     = 1'b0;
        bursts_on        = 1'b0;
        stall_left       = 0;
        frame_items      = 0;
        settings_loaded  = 0;
        cur_head         = '0;
        cur_tail         = '0;
        cur_cmds         = '0;
        cur_modes        = '0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers at reset: every code byte is zero, so write and normal always win
        repeat (5) send_frame();
        settle();

        // Directed frames: head AA 55, tail 0D F0, commands 10/20/30/40,
        // modes 00/01/FF/80
        apply_settings(16'hAA55, 16'h0DF0, 32'h1020_3040, 32'h0001_FF80);
        // no frame open yet: dropped
        send_byte(8'h5A, 1'b0, 1'b0);
        // bad first head byte that is also the buffer's last byte
        send_byte(8'h00, 1'b1, 1'b1);
        // read frame cut off by a new first byte, then a complete ack frame
        send_byte(8'hAA, 1'b1, 1'b0); send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0); send_byte(8'h20, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b1, 1'b0); send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0); send_byte(8'h30, 1'b0, 1'b0);
        send_byte(8'h0D, 1'b0, 1'b0); send_byte(8'hF0, 1'b0, 1'b1);
        // write frame whose mode byte names no mode
        send_byte(8'hAA, 1'b1, 1'b0); send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0); send_byte(8'h10, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0); send_byte(8'h77, 1'b0, 1'b0);
        // match frame that ends inside the address
        send_byte(8'hAA, 1'b1, 1'b0); send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'h02, 1'b0, 1'b0); send_byte(8'h40, 1'b0, 1'b0);
        send_byte(8'hDE, 1'b0, 1'b0); send_byte(8'hAD, 1'b0, 1'b1);
        // unknown command byte
        send_byte(8'hAA, 1'b1, 1'b0); send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'h03, 1'b0, 1'b0); send_byte(8'h99, 1'b0, 1'b0);
        settle();

        // Random phases: extremes first, then colliding codes, then distinct codes.
        // Even phases idle both sides in bursts; the last phase runs flat out.
        quota = frame_items;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       apply_settings(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                1:       apply_settings(16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
                2:       apply_settings(16'($urandom), 16'($urandom),
                                        random_codes(1'b1), random_codes(1'b1));
                default: apply_settings(16'($urandom), 16'($urandom),
                                        random_codes(1'b0), random_codes(1'b0));
            endcase
            bursts_on = (ph % 2 == 0) && (ph != 7);
            quota += 150;
            while (frame_items < quota)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // raw noise: random bytes with random buffer marks
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom), $urandom_range(0, 3) == 0,
                                  $urandom_range(0, 3) == 0);
                end
                else
                begin
                    send_frame();
                end
            end
            settle();
        end

        repeat (8) @(negedge clk);
        $display("took %0d bytes; checked %0d field items and %0d frame ends, %0d of them ok",
                 bytes_taken, fields_seen, statuses_seen, frames_ok);
        $display("across %0d register settings, including all-zero and all-ones codes",
                 settings_loaded);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
